### rtl/fps_pkg.sv
// Package for the Fenwick tree point-set / prefix-sum block.
// Holds sizes, opcodes, FSM state type and controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package fps_pkg;

    // Number of elements held in the tree
    localparam int NUM_ELEMENTS = 16;

    // Fixed field widths of the item and result beats
    localparam int IDX_W = 5;
    localparam int VAL_W = 32;

    // Element address and walk position widths; the walk can run up to 2*N
    localparam int ADDR_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int POS_W  = (ADDR_W + 2 > IDX_W + 1) ? ADDR_W + 2 : IDX_W + 1;

    localparam logic [POS_W-1:0] NUM_POS = POS_W'(NUM_ELEMENTS);

    typedef logic [IDX_W-1:0]  t_index;
    typedef logic [VAL_W-1:0]  t_value;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [0:0] {
        OP_SET   = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ELEM,
        S_SET,
        S_QRY,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the accepted item
        logic elem_wr;   // form the change and write the element
        logic set_step;  // add change to one partial sum, climb the chain
        logic qry_step;  // accumulate one partial sum, descend the chain
        logic out_load;  // move the total into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_is_query;
        logic in_set_ok;
        logic pos_zero;
        logic pos_over;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### rtl/fps_item_if.sv
// Valid/ready channels of the Fenwick tree block: item beat and result beat.
// Depends on fps_pkg.
`default_nettype none

interface fps_item_if import fps_pkg::*; ();
    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_index  index;
    t_value  value;

    modport source (output valid, output opcode, output index, output value, input ready);
    modport sink   (input valid, input opcode, input index, input value, output ready);
endinterface

interface fps_result_if import fps_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value prefix_total;

    modport source (output valid, output prefix_total, input ready);
    modport sink   (input valid, input prefix_total, output ready);
endinterface

`default_nettype wire

### rtl/fps_ctrl.sv
// Controller FSM of the Fenwick tree block: sequences set and query walks.
// Depends on fps_pkg; drives the datapath through t_cmd, reads t_sts.
`default_nettype none

module fps_ctrl import fps_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_sts.in_is_query) begin
                        n_state = S_QRY;
                    end else if (i_sts.in_set_ok) begin
                        n_state = S_ELEM;
                    end
                end
            end
            S_ELEM: n_state = S_SET;
            S_SET: begin
                if (i_sts.pos_over) begin
                    n_state = S_IDLE;
                end
            end
            S_QRY: begin
                if (i_sts.pos_zero) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_ELEM: o_cmd.elem_wr  = 1'b1;
            S_SET:  o_cmd.set_step = !i_sts.pos_over;
            S_QRY:  o_cmd.qry_step = !i_sts.pos_zero;
            S_EMIT: o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/fps_datapath.sv
// Datapath of the Fenwick tree block: element and partial-sum stores, walk
// position, change and running total, and the result register. Depends on fps_pkg.
`default_nettype none

module fps_datapath import fps_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cmd    i_cmd,
    output t_sts         o_sts,
    input  wire t_opcode i_opcode,
    input  wire t_index  i_index,
    input  wire t_value  i_value,
    input  wire logic    i_out_ready,
    output logic         o_out_valid,
    output t_value       o_prefix_total
);

    t_value r_elem [NUM_ELEMENTS];
    t_value r_psum [NUM_ELEMENTS];
    t_pos   r_pos;
    t_value r_value;
    t_value r_change;
    t_value r_total;
    t_value r_out_data;
    logic   r_out_valid;

    t_pos   idx_ext;
    t_pos   pos_m1;
    t_pos   low_bit;
    t_addr  addr;

    // Index handling and lowest set bit of the walk position
    assign idx_ext = POS_W'(i_index);
    assign pos_m1  = r_pos - POS_W'(1);
    assign addr    = pos_m1[ADDR_W-1:0];
    assign low_bit = r_pos & (~r_pos + POS_W'(1));

    // Status back to the controller
    always_comb begin
        o_sts.in_is_query = (i_opcode == OP_QUERY);
        o_sts.in_set_ok   = (idx_ext != '0) && (idx_ext <= NUM_POS);
        o_sts.pos_zero    = (r_pos == '0);
        o_sts.pos_over    = (r_pos > NUM_POS);
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    // Stores, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_ELEMENTS; k++) begin
                r_elem[k] <= '0;
                r_psum[k] <= '0;
            end
        end else begin
            if (i_cmd.elem_wr) begin
                r_elem[addr] <= r_value;
            end
            if (i_cmd.set_step) begin
                r_psum[addr] <= r_psum[addr] + r_change;
            end
        end
    end

    // Walk position, change and running total
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // a query past the end saturates to the last element
            if (i_opcode == OP_QUERY && idx_ext > NUM_POS) begin
                r_pos <= NUM_POS;
            end else begin
                r_pos <= idx_ext;
            end
            r_value <= i_value;
            r_total <= '0;
        end
        if (i_cmd.elem_wr) begin
            r_change <= r_value - r_elem[addr];
        end
        if (i_cmd.set_step) begin
            r_pos <= r_pos + low_bit;
        end
        if (i_cmd.qry_step) begin
            r_total <= r_total + r_psum[addr];
            r_pos   <= r_pos - low_bit;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_total;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_prefix_total = r_out_data;

endmodule

`default_nettype wire

### rtl/fenwick_point_set_prefix_sum.sv
// Fenwick tree with point set and prefix-sum query over NUM_ELEMENTS elements.
// Beats are taken one at a time, one store access per cycle: a set writes its element,
//   then one partial sum per step on the index's chain (up to log2(N)+1); an ignored
//   set has no walk; a query adds one partial sum per set bit of the saturated index.
// A full result register holds the finished query total until the waiting beat leaves.
// One item in flight; reset (synchronous, active low) clears both stores at once.
`default_nettype none

module fenwick_point_set_prefix_sum import fps_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    fps_item_if.sink     i_item,
    fps_result_if.source o_result
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    // Controller
    fps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath
    fps_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_opcode       (i_item.opcode),
        .i_index        (i_item.index),
        .i_value        (i_item.value),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_prefix_total (o_result.prefix_total)
    );

    assign i_item.ready = in_ready;

    // At most one datapath action per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.elem_wr, cmd.set_step, cmd.qry_step, cmd.out_load}))
        else $error("more than one datapath command");

    // No walk step while the input side is open
    a_busy_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready |-> !(cmd.elem_wr || cmd.set_step || cmd.qry_step || cmd.out_load))
        else $error("datapath step while accepting items");

    // The set walk never touches a partial sum past the last element
    a_set_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.set_step |-> !sts.pos_over)
        else $error("set walk out of range");

    // A result beat only appears after a load of the total
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(cmd.out_load))
        else $error("result beat without total load");

endmodule

`default_nettype wire

### verif/fenwick_point_set_prefix_sum_tb.sv
// Self-checking testbench for the Fenwick tree point-set / prefix-sum block.
// Drives set and query beats, keeps its own binary indexed tree and checks every total.
// Depends on fps_pkg, fps_item_if, fps_result_if and fenwick_point_set_prefix_sum.
`default_nettype none

module fenwick_point_set_prefix_sum_tb;
    import fps_pkg::*;

    localparam int TAIL_BEATS   = 150;  // last beats run with no idling on either side
    localparam int HOLD_AFTER   = 400;  // long result hold-off starts after this many beats
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BEATS = 1650;
    localparam int DRAIN_CYCLES = 16;   // longest set or query walk, with margin

    typedef struct {
        t_opcode opcode;
        t_index  index;
        t_value  value;
    } t_item_beat;

    logic clk;
    logic rst_n;

    fps_item_if   item_ch ();
    fps_result_if result_ch ();

    fenwick_point_set_prefix_sum dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch.sink),
        .o_result (result_ch.source)
    );

    t_item_beat pending_beats[$];
    t_value     expected_totals[$];
    int         total_beats;
    int         items_taken;
    int         error_count = 0;
    logic       quiet_tail;
    logic       hold_rx;
    int         gap_left;
    int         stall_left;

    // Shadow tree: element values and partial sums, both 1-based
    t_value element_now [1:NUM_ELEMENTS];
    t_value chain_sum   [1:NUM_ELEMENTS];

    function automatic int unsigned lowest_bit(int unsigned k);
        return k & (~k + 1);
    endfunction

    // Point set: push the change up the lowest-set-bit chain
    task automatic fenwick_set(t_index idx, t_value v);
        int unsigned k;
        t_value      delta;
        if (idx == 0 || idx > NUM_ELEMENTS) return;
        delta = v - element_now[idx];
        element_now[idx] = v;
        k = idx;
        while (k <= NUM_ELEMENTS) begin
            chain_sum[k] += delta;
            k += lowest_bit(k);
        end
    endtask

    // Prefix total; an index past the end saturates to the whole tree
    function automatic t_value fenwick_prefix(t_index idx);
        int unsigned k;
        t_value      total;
        total = '0;
        k = (idx > NUM_ELEMENTS) ? NUM_ELEMENTS : idx;
        while (k != 0) begin
            total += chain_sum[k];
            k -= lowest_bit(k);
        end
        return total;
    endfunction

    task automatic push_beat(t_opcode op, t_index idx, t_value v);
        t_item_beat b;
        b.opcode = op;
        b.index  = idx;
        b.value  = v;
        pending_beats.push_back(b);
    endtask

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Item driver: presents the head of the queue, predicts on acceptance
    always @(posedge clk) begin : item_driver
        logic       next_valid;
        t_item_beat head;
        if (!rst_n) begin
            item_ch.valid <= 1'b0;
            quiet_tail    <= 1'b0;
            items_taken   <= 0;
            gap_left      <= 0;
            foreach (element_now[k]) begin
                element_now[k] = '0;
                chain_sum[k]   = '0;
            end
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                head = pending_beats.pop_front();
                if (head.opcode == OP_QUERY)
                    expected_totals.push_back(fenwick_prefix(head.index));
                else
                    fenwick_set(head.index, head.value);
                items_taken <= items_taken + 1;
            end
            quiet_tail <= (pending_beats.size() < TAIL_BEATS);
            // only move on once the current beat is gone
            if (!(item_ch.valid && !item_ch.ready)) begin
                next_valid = 1'b0;
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_beats.size() != 0) begin
                    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                        gap_left <= $urandom_range(0, 5);
                    end else begin
                        item_ch.opcode <= pending_beats[0].opcode;
                        item_ch.index  <= pending_beats[0].index;
                        item_ch.value  <= pending_beats[0].value;
                        next_valid = 1'b1;
                    end
                end
                item_ch.valid <= next_valid;
            end
        end
    end

    // Result ready: random stall bursts, plus the long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
        end else if (hold_rx) begin
            result_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left      <= stall_left - 1;
            result_ch.ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left      <= $urandom_range(0, 5);
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge clk) begin : total_monitor
        t_value want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_totals.size() == 0) begin
                $error("prefix_total: beat with no query outstanding, expected none, actual %0d",
                       $signed(result_ch.prefix_total));
                error_count++;
            end else begin
                want = expected_totals.pop_front();
                if (result_ch.prefix_total !== want) begin
                    $error("prefix_total mismatch: expected %0d, actual %0d",
                           $signed(want), $signed(result_ch.prefix_total));
                    error_count++;
                end
            end
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input
    initial begin
        hold_rx = 1'b0;
        wait (items_taken >= HOLD_AFTER);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        int      pick;
        t_opcode op;
        t_index  idx;
        t_value  v;
        logic    leftover;

        rst_n = 1'b0;

        // Directed: empty tree, extremes, ignored sets, saturating queries
        push_beat(OP_QUERY, 5'd0,  '0);
        push_beat(OP_QUERY, 5'd16, '0);
        push_beat(OP_SET,   5'd1,  32'h7FFF_FFFF);
        push_beat(OP_SET,   5'd16, 32'h8000_0000);
        push_beat(OP_SET,   5'd0,  32'd5);
        push_beat(OP_SET,   5'd17, 32'd9);
        push_beat(OP_SET,   5'd31, 32'hFFFF_FFFF);
        push_beat(OP_QUERY, 5'd31, 32'hFFFF_FFFF);
        push_beat(OP_QUERY, 5'd17, '0);
        push_beat(OP_QUERY, 5'd16, '0);
        push_beat(OP_QUERY, 5'd15, '0);
        push_beat(OP_QUERY, 5'd1,  '0);
        push_beat(OP_QUERY, 5'd0,  '0);
        push_beat(OP_SET,   5'd8,  32'hFFFF_FFFF);
        push_beat(OP_SET,   5'd1,  32'hFFFF_FFFF);
        push_beat(OP_SET,   5'd2,  32'd1);
        push_beat(OP_QUERY, 5'd2,  '0);
        push_beat(OP_QUERY, 5'd8,  '0);
        push_beat(OP_QUERY, 5'd7,  '0);
        push_beat(OP_SET,   5'd16, 32'h7FFF_FFFF);
        push_beat(OP_QUERY, 5'd16, '0);
        push_beat(OP_QUERY, 5'd31, '0);
        push_beat(OP_SET,   5'd4,  32'h8000_0000);
        push_beat(OP_QUERY, 5'd5,  '0);

        // Random: mostly in-range indices, some zero and past-the-end
        while (pending_beats.size() < RANDOM_BEATS) begin
            op = ($urandom_range(0, 1) != 0) ? OP_QUERY : OP_SET;
            pick = $urandom_range(0, 19);
            if (pick == 0)
                idx = '0;
            else if (pick <= 2)
                idx = t_index'($urandom_range(NUM_ELEMENTS + 1, 31));
            else
                idx = t_index'($urandom_range(1, NUM_ELEMENTS));
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    v = 32'h7FFF_FFFF;
                end
                1: begin
                    v = 32'h8000_0000;
                end
                2: begin
                    v = t_value'($urandom_range(0, 200)) - 32'd100;
                end
                default: begin
                    v = $urandom();
                end
            endcase
            push_beat(op, idx, v);
        end
        total_beats = pending_beats.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (items_taken == total_beats);
        while (expected_totals.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        leftover = (expected_totals.size() != 0);
        if (leftover)
            $error("prefix_total: %0d expected totals never arrived", expected_totals.size());
        if (error_count == 0 && !leftover) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
